@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers; the enclosing module provides clk and rst.
`ifndef SYNTHESIS
`define P4D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define P4D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define P4D_ASSERT(lbl, prop, msg)
`define P4D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/p4d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package p4d_pkg;
  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned SINGULAR_GAIN_DEF = 1000000;

  localparam logic [1:0] MODE_PERSP  = 2'd0;
  localparam logic [1:0] MODE_STEREO = 2'd1;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIST = 1'b1;

  // What the lanes do with an item
  typedef enum logic [3:0] {
    K_DIV   = 4'b0001,
    K_PSING = 4'b0010,
    K_SSING = 4'b0100,
    K_ORTHO = 4'b1000
  } kind_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    kind_t              kind;
    logic               qneg;
    logic               ssign;
  } side_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sing;
    logic        clip;
  } out_t;
endpackage
`default_nettype wire

@@ sv/p4d_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module p4d_div #(
  parameter int unsigned QW = 48
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [QW-1:0]     dvd_in,
  input  wire logic [32:0]       dsr_in,
  input  wire p4d_pkg::side_t    side_in,
  output logic      [QW-1:0]     quo,
  output p4d_pkg::side_t         side_out
);
  import p4d_pkg::*;

  localparam int unsigned RW = 34;

  logic [QW-1:0] dvd_r  [QW];
  logic [RW-1:0] rem_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [32:0]   dsr_r  [QW];
  side_t         side_r [QW];

  // One quotient bit per stage, restoring form
  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [QW-1:0] dvd_s;
    logic [QW-1:0] q_s;
    logic [RW-1:0] rem_s;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] rem_d;
    logic [32:0]   dsr_s;
    side_t         side_s;
    logic          ge;

    if (k == 0) begin : g_first
      assign dvd_s  = dvd_in;
      assign q_s    = '0;
      assign rem_s  = '0;
      assign dsr_s  = dsr_in;
      assign side_s = side_in;
    end else begin : g_next
      assign dvd_s  = dvd_r[k-1];
      assign q_s    = q_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign dsr_s  = dsr_r[k-1];
      assign side_s = side_r[k-1];
    end

    assign rem_sh = {rem_s[RW-2:0], dvd_s[QW-1]};
    assign ge     = rem_sh >= {1'b0, dsr_s};
    assign rem_d  = ge ? rem_sh - {1'b0, dsr_s} : rem_sh;

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[k]  <= {dvd_s[QW-2:0], 1'b0};
        rem_r[k]  <= rem_d;
        q_r[k]    <= {q_s[QW-2:0], ge};
        dsr_r[k]  <= dsr_s;
        side_r[k] <= side_s;
      end
    end
  end

  assign quo      = q_r[QW-1];
  assign side_out = side_r[QW-1];
endmodule
`default_nettype wire

@@ sv/p4d_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module p4d_lane #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned SINGULAR_GAIN = 1000000
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire p4d_pkg::kind_t     kind_in,
  input  wire logic signed [31:0] coord_in,
  input  wire logic signed [31:0] factor_in,
  input  wire logic               ssign_in,
  output logic        [31:0]      res,
  output logic                    clip
);
  import p4d_pkg::*;

  localparam logic signed [31:0] GAIN = 32'(SINGULAR_GAIN);
  localparam logic signed [63:0] BIG  = 64'(SINGULAR_GAIN) <<< FRAC_BITS;
  localparam logic signed [63:0] RND  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  kind_t              kind_r;
  logic signed [31:0] coord_r;
  logic               ssign_r;
  logic signed [63:0] rnd;
  logic signed [63:0] val;

  assign mul_b = (kind_in == K_PSING) ? GAIN : factor_in;

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= coord_in * mul_b;
      kind_r  <= kind_in;
      coord_r <= coord_in;
      ssign_r <= ssign_in;
    end
  end

  // Truncate toward zero before the shift
  assign rnd = prod + (prod[63] ? RND : 64'sd0);

  always_comb begin
    unique case (kind_r)
      K_DIV:   val = rnd >>> FRAC_BITS;
      K_PSING: val = prod;
      K_SSING: val = ssign_r ? -BIG : BIG;
      default: val = {{32{coord_r[31]}}, coord_r};
    endcase
    if (val > MAXV) begin
      res  = 32'h7FFF_FFFF;
      clip = 1'b1;
    end else if (val < MINV) begin
      res  = 32'h8000_0000;
      clip = 1'b1;
    end else begin
      res  = val[31:0];
      clip = 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/projection_4d_to_3d.sv @@
// Channel   Dir  Handshake                Contents
// s_        in   s_tvalid / s_tready      one 4D point per item
// m_        out  m_tvalid / m_tready      one 3D point plus flags per item
// apb       in   psel/penable/pwrite      mode and viewer distance
// The pipeline is a front stage, one divider stage per quotient bit (32 + FRAC_BITS),
// a factor stage, a multiply stage in each of the three lanes and the output register.
// One item enters per cycle while the skid entry is empty (s_tready high).
// rst is synchronous and clears all valid flags and sets mode and distance to their defaults.
// A two-entry output (register plus skid) keeps taking items during a stall;
// s_tready falls only once the skid entry is occupied.
`timescale 1ns / 1ps
`default_nettype none
module projection_4d_to_3d #(
  parameter int unsigned FRAC_BITS     = p4d_pkg::FRAC_BITS_DEF,
  parameter int unsigned SINGULAR_GAIN = p4d_pkg::SINGULAR_GAIN_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // coord_x, coord_y, coord_z, coord_w
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [95:0]  m_tdata,  // proj_x, proj_y, proj_z
  output logic      [1:0]   m_tuser,  // singular, clipped
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import p4d_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned QW = 32 + FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  logic [1:0]         mode;
  logic signed [31:0] view_dist;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIST) ? view_dist : {30'd0, mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_PERSP;
      view_dist <= 32'sd131072;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MODE) mode <= pwdata[1:0];
      else                      view_dist <= pwdata;
    end
  end

  logic en;
  logic v0, vd, vf, vl;
  logic ov, sv;
  out_t out_r, skid_r, new_item;

  assign en       = !sv;
  assign s_tready = !sv;

  // Front stage
  logic signed [31:0] cx, cy, cz, cw, num;
  logic signed [32:0] den;
  logic [31:0]        num_abs;
  logic [32:0]        den_abs;
  logic signed [33:0] csum;
  side_t              side_c, side_f;
  logic [QW-1:0]      dvd_f;
  logic [32:0]        dsr_f;

  assign cx = s_tdata[31:0];
  assign cy = s_tdata[63:32];
  assign cz = s_tdata[95:64];
  assign cw = s_tdata[127:96];
  assign num     = (mode == MODE_PERSP) ? view_dist : ONE;
  assign den     = 33'(num) - 33'(cw);
  assign num_abs = num[31] ? 32'(-num) : num;
  assign den_abs = den[32] ? 33'(-den) : den;
  assign csum    = 34'(cx) + 34'(cy) + 34'(cz);

  always_comb begin
    side_c.x     = cx;
    side_c.y     = cy;
    side_c.z     = cz;
    side_c.qneg  = num[31] ^ den[32];
    side_c.ssign = csum[33];
    priority if (mode == MODE_PERSP)
      side_c.kind = (den == '0) ? K_PSING : K_DIV;
    else if (mode == MODE_STEREO)
      side_c.kind = (den == '0) ? K_SSING : K_DIV;
    else
      side_c.kind = K_ORTHO;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_f  <= {num_abs, {FRAC_BITS{1'b0}}};
      dsr_f  <= den_abs;
      side_f <= side_c;
    end
  end

  logic [QW-1:0] quo;
  side_t         side_d;

  p4d_div #(.QW(QW)) u_div (
    .clk(clk), .en(en), .dvd_in(dvd_f), .dsr_in(dsr_f), .side_in(side_f),
    .quo(quo), .side_out(side_d)
  );

  // Factor stage: sign and saturate the quotient
  logic signed [31:0] fac;
  logic               fclip;
  side_t              side_q;
  logic signed [31:0] fac_c;
  logic               fclip_c;

  always_comb begin
    if (side_d.qneg) begin
      fclip_c = quo > QW'(33'h0_8000_0000);
      fac_c   = fclip_c ? 32'sh8000_0000 : 32'(-quo[31:0]);
    end else begin
      fclip_c = quo > QW'(33'h0_7FFF_FFFF);
      fac_c   = fclip_c ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fac    <= fac_c;
      fclip  <= fclip_c && (side_d.kind == K_DIV);
      side_q <= side_d;
    end
  end

  logic [31:0] rx, ry, rz;
  logic        clx, cly, clz;
  kind_t       kind_l;
  logic        fclip_l;

  p4d_lane #(.FRAC_BITS(FRAC_BITS), .SINGULAR_GAIN(SINGULAR_GAIN)) u_lane_x (
    .clk(clk), .en(en), .kind_in(side_q.kind), .coord_in(side_q.x), .factor_in(fac),
    .ssign_in(side_q.ssign), .res(rx), .clip(clx)
  );
  p4d_lane #(.FRAC_BITS(FRAC_BITS), .SINGULAR_GAIN(SINGULAR_GAIN)) u_lane_y (
    .clk(clk), .en(en), .kind_in(side_q.kind), .coord_in(side_q.y), .factor_in(fac),
    .ssign_in(side_q.ssign), .res(ry), .clip(cly)
  );
  p4d_lane #(.FRAC_BITS(FRAC_BITS), .SINGULAR_GAIN(SINGULAR_GAIN)) u_lane_z (
    .clk(clk), .en(en), .kind_in(side_q.kind), .coord_in(side_q.z), .factor_in(fac),
    .ssign_in(side_q.ssign), .res(rz), .clip(clz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      kind_l  <= side_q.kind;
      fclip_l <= fclip;
    end
  end

  // Merge the lanes
  always_comb begin
    new_item.x    = rx;
    new_item.y    = ry;
    new_item.z    = rz;
    new_item.sing = (kind_l == K_PSING) || (kind_l == K_SSING);
    new_item.clip = fclip_l || clx || cly || clz;
  end

  // Valid flags of the fixed-latency pipeline
  logic [QW-1:0] vdiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      vdiv <= '0;
      vf   <= 1'b0;
      vl   <= 1'b0;
    end else if (en) begin
      v0   <= s_tvalid;
      vdiv <= {vdiv[QW-2:0], v0};
      vf   <= vdiv[QW-1];
      vl   <= vf;
    end
  end
  assign vd = vdiv[QW-1];

  logic pop, take;
  assign pop  = ov && m_tready;
  assign take = vl && !sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (pop) begin
        sv <= 1'b0;
      end
    end else if (take) begin
      if (!ov || pop) ov <= 1'b1;
      else            sv <= 1'b1;
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (pop) out_r <= skid_r;
    end else if (take) begin
      if (!ov || pop) out_r  <= new_item;
      else            skid_r <= new_item;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {out_r.z, out_r.y, out_r.x};
  assign m_tuser  = {out_r.clip, out_r.sing};

  `P4D_ASSERT(a_skid_needs_out, sv |-> ov, "skid occupied while output empty")
  `P4D_ASSERT_NEXT(a_out_held, ov && !m_tready, ov && $stable(m_tdata), "output lost in stall")
  `P4D_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v0, "accepted item not in front stage")
  `P4D_ASSERT_NEXT(a_div_exit, vd && en, vf, "divider item lost before factor stage")
endmodule
`default_nettype wire

@@ tb/projection_checker.sv @@
`timescale 1ns / 1ps
module projection_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_points
);
  import p4d_pkg::*;

  localparam int FB = int'(FRAC_BITS_DEF);
  localparam longint GAIN = longint'(SINGULAR_GAIN_DEF);

  logic [1:0]         cur_mode;
  logic signed [31:0] cur_dist;
  out_t               projected_q[$];

  assign pending_points = projected_q.size();

  function automatic longint clamp32(input longint v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_t project_point(input logic [127:0] pt);
    longint c[3];
    longint w, den, num, f, v;
    logic clip;
    out_t o;
    clip = 1'b0;
    o.sing = 1'b0;
    for (int i = 0; i < 3; i++) c[i] = longint'($signed(pt[32*i +: 32]));
    w = longint'($signed(pt[127:96]));
    if (cur_mode == MODE_PERSP || cur_mode == MODE_STEREO) begin
      num = (cur_mode == MODE_PERSP) ? longint'(cur_dist) : (64'sd1 <<< FB);
      den = num - w;
      if (den == 0) begin
        o.sing = 1'b1;
        if (cur_mode == MODE_PERSP) begin
          for (int i = 0; i < 3; i++) c[i] = clamp32(c[i] * GAIN, clip);
        end else begin
          v = (c[0] + c[1] + c[2] >= 0) ? GAIN * (64'sd1 <<< FB) : -GAIN * (64'sd1 <<< FB);
          v = clamp32(v, clip);
          for (int i = 0; i < 3; i++) c[i] = v;
        end
      end else begin
        // SV division truncates toward zero, as required
        f = clamp32((num * (64'sd1 <<< FB)) / den, clip);
        for (int i = 0; i < 3; i++) c[i] = clamp32((c[i] * f) / (64'sd1 <<< FB), clip);
      end
    end
    o.x = c[0][31:0];
    o.y = c[1][31:0];
    o.z = c[2][31:0];
    o.clip = clip;
    return o;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      cur_mode <= MODE_PERSP;
      cur_dist <= 32'sd131072;
      fail_count <= 0;
      projected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) cur_mode <= pwdata[1:0];
        else cur_dist <= pwdata;
      end
      if (s_tvalid && s_tready) projected_q.push_back(project_point(s_tdata));
      if (m_tvalid && m_tready) begin
        if (projected_q.size() == 0) begin
          $display("%0t: unexpected item got %h/%b", $time, m_tdata, m_tuser);
          fail_count <= fail_count + 1;
        end else begin
          e = projected_q.pop_front();
          if (m_tdata !== {e.z, e.y, e.x} || m_tuser !== {e.clip, e.sing}) begin
            $display("%0t: mismatch expected %h/%b%b got %h/%b", $time,
                     {e.z, e.y, e.x}, e.clip, e.sing, m_tdata, m_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import p4d_pkg::*;

  localparam int LATENCY = 52;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_ORTHO = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_DIST = {REG_DIST, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, m_tready = 1'b0;
  logic [127:0] s_tdata = '0;
  logic s_tready, m_tvalid, pready;
  logic [95:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int fail_count, pending_points;
  int cycles = 0;
  bit hold_sink = 1'b0;
  logic [31:0] dist_now = 32'd131072;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  projection_4d_to_3d dut (.*);
  projection_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sink: random wait per item, plus a long hold when requested
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 1)) gap = 0;
      if (hold_sink) begin
        gap = 300;
        hold_sink = 1'b0;
      end
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_DIST) dist_now = val;
  endtask

  // Hold the item until accepted; s_tvalid stays up for back-to-back items
  task automatic send_point(input logic [31:0] x, y, z, w, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {w, z, y, x};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    s_tvalid <= 1'b0;
    while (pending_points != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? $urandom() : -$urandom_range(0, 32'h0004_0000);
      3: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_w(input logic [1:0] m);
    case ($urandom_range(0, 7))
      0: return (m == MODE_STEREO) ? ONE_Q : dist_now;
      1: return ((m == MODE_STEREO) ? ONE_Q : dist_now) + $urandom_range(0, 2) - 1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return pick_coord();
    endcase
  endfunction

  initial begin
    logic [1:0] modes[4];
    logic [31:0] dists[5];
    bit burst;
    modes = '{MODE_PERSP, MODE_STEREO, MODE_ORTHO, MODE_SPARE};
    dists = '{32'd131072, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFE_0000};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes in each mode, singular points in perspective and stereo mode
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 0);
    send_point(32'd65536, 32'hFFFF_0000, 32'd3, 32'd131072, 0);
    send_point(32'h8000_0000, 32'd0, 32'd0, 32'd131072, 0);
    send_point(32'd5, 32'd7, 32'hFFFF_FFFF, 32'd131071, 0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    drain_wait();
    write_reg(ADDR_MODE, 32'(MODE_STEREO));
    send_point(32'd1, 32'hFFFF_FFFF, 32'd0, ONE_Q, 0);
    send_point(32'hFFFF_FFFF, 32'd0, 32'd0, ONE_Q, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE_Q - 1, 0);
    send_point(32'd65536, 32'd65536, 32'd65536, 32'hFFFF_0000, 0);
    send_point(32'h8000_0000, 32'd3, 32'd9, 32'h8000_0000, 0);
    drain_wait();
    write_reg(ADDR_MODE, 32'(MODE_ORTHO));
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 0);
    drain_wait();
    write_reg(ADDR_MODE, 32'(MODE_SPARE));
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'd0, 0);
    drain_wait();

    // random phases over modes and distances; phase 3 overfills the pipeline
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(ADDR_MODE, 32'(modes[ph % 4]));
      write_reg(ADDR_DIST, (ph < 5) ? dists[ph] : pick_coord());
      if (ph == 3) hold_sink = 1'b1;
      for (int n = 0; n < ((ph == 3) ? 90 : 43); n++) begin
        burst = (ph == 3) || ($urandom_range(0, 3) == 0);
        send_point(pick_coord(), pick_coord(), pick_coord(),
                   pick_w(modes[ph % 4]), burst);
      end
      drain_wait();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/p4d_pkg.sv
sv/p4d_div.sv
sv/p4d_lane.sv
sv/projection_4d_to_3d.sv
tb/projection_checker.sv
tb/tb_top.sv
